// File: rtl/rpc_pkg.sv
// Package for the restricted partition counter: defaults, codes, FSM and control types.
package rpc_pkg;

  // Default structural parameters
  localparam int SIZE_MAX_DEF    = 63;
  localparam int PART_MAX_DEF    = 63;
  localparam int MOD_MAX_DEF     = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // Input item kinds (tuser)
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODULUS  = 2'd0;
  localparam logic [1:0] CFG_MAX_SIZE = 2'd1;
  localparam logic [1:0] CFG_FORBID   = 2'd2;

  // Reset values of the configuration registers
  localparam logic [4:0]  MODULUS_RST  = 5'd8;
  localparam logic [5:0]  MAX_SIZE_RST = 6'd63;
  localparam logic [62:0] FORBID_RST   = '0;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_N_INIT,
    S_P_TEST,
    S_P_START,
    S_RD_DIFF,
    S_RD_CNT,
    S_ACC,
    S_WR,
    S_SUM,
    S_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_diff;  // write one difference entry
    logic run_start;  // latch clamped config, n = 0
    logic row_init;   // seed row p = 0 for this n
    logic p_start;    // acc = cur[pr], rr = 0
    logic rd_diff;    // issue difference read
    logic rd_cnt;     // issue count table read
    logic acc_step;   // accumulate one residue
    logic wr_row;     // write one entry of row p
    logic sum_step;   // add one residue into total
    logic n_inc;      // next size
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic p_over;   // no more parts for this size
    logic rr_last;  // residue index at m-1
    logic forbid;   // current part is forbidden
    logic n_last;   // current size is the last one
  } status_t;

endpackage

// File: rtl/restricted_partition_counter.sv
// Restricted partition counter: top level joining sequencer and datapath.
// A load item takes 1 cycle; one item is worked on at a time. A run emits one result
// per size n = 0..max_size; size n costs 3 + m + sum over parts p = 1..n of (2 + 4m)
// cycles (2 + m for a forbidden part) plus output stalls, set by the single count table
// read port (3 cycles per residue read, 1 per write): about 134k cycles at m = 16.
// Reset (rst, synchronous) returns the sequencer to idle and config registers to defaults.
module restricted_partition_counter
  import rpc_pkg::*;
#(
  parameter int SIZE_MAX    = SIZE_MAX_DEF,
  parameter int PART_MAX    = PART_MAX_DEF,
  parameter int MOD_MAX     = MOD_MAX_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // row [3:0], col [7:4], diff_value [15:8]
  input  logic        s_tuser,   // func [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // size [5:0], count [37:6], zero [39:38]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  cmd_t        cmd;
  status_t     status;
  logic [5:0]  size;
  logic [31:0] count;

  rpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_func   (s_tuser),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rpc_dpath #(
    .SIZE_MAX    (SIZE_MAX),
    .PART_MAX    (PART_MAX),
    .MOD_MAX     (MOD_MAX),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .row        (s_tdata[3:0]),
    .col        (s_tdata[7:4]),
    .diff_value (s_tdata[15:8]),
    .cmd        (cmd),
    .status     (status),
    .size       (size),
    .count      (count),
    .last       (m_tlast)
  );

  assign m_tdata = {2'b00, count, size};

  // A result on the output means no input is taken
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input ready while a result is pending");

  // Count table is written only during a run
  assert property (@(posedge clk) disable iff (rst) cmd.wr_row |-> !s_tready && !m_tvalid)
    else $error("count table write outside a run");

  // A stalled result holds its data
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // The final result of a run returns the block to idle
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready)
    else $error("block not idle after last result");

endmodule

// File: rtl/rpc_ram.sv
// Generic single write port, single read port RAM with registered read.
module rpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/rpc_ctrl.sv
// Sequencer for the partition counter: walks sizes, parts and residues.
module rpc_ctrl
  import rpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    s_func,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_func == FUNC_RUN) begin
            cmd.run_start = 1'b1;
            state_next    = S_N_INIT;
          end else begin
            cmd.load_diff = 1'b1;
          end
        end
      end
      S_N_INIT: begin
        cmd.row_init = 1'b1;
        state_next   = S_P_TEST;
      end
      S_P_TEST: begin
        state_next = status.p_over ? S_SUM : S_P_START;
      end
      S_P_START: begin
        cmd.p_start = 1'b1;
        state_next  = status.forbid ? S_WR : S_RD_DIFF;
      end
      S_RD_DIFF: begin
        cmd.rd_diff = 1'b1;
        state_next  = S_RD_CNT;
      end
      S_RD_CNT: begin
        cmd.rd_cnt = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_step = 1'b1;
        state_next   = status.rr_last ? S_WR : S_RD_DIFF;
      end
      S_WR: begin
        cmd.wr_row = 1'b1;
        if (status.rr_last) begin
          state_next = S_P_TEST;
        end
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.rr_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (status.n_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.n_inc  = 1'b1;
            state_next = S_N_INIT;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/rpc_dpath.sv
// Datapath: config registers, tables, counters, row vector and saturating adder.
module rpc_dpath
  import rpc_pkg::*;
#(
  parameter int SIZE_MAX    = SIZE_MAX_DEF,
  parameter int PART_MAX    = PART_MAX_DEF,
  parameter int MOD_MAX     = MOD_MAX_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_data,
  input  logic [3:0]  row,
  input  logic [3:0]  col,
  input  logic [7:0]  diff_value,
  input  cmd_t        cmd,
  output status_t     status,
  output logic [5:0]  size,
  output logic [31:0] count,
  output logic        last
);

  localparam int SB  = $clog2(SIZE_MAX + 1);
  localparam int PB  = $clog2(PART_MAX + 1);
  localparam int MB  = (MOD_MAX > 1) ? $clog2(MOD_MAX) : 1;
  localparam int MW  = $clog2(MOD_MAX + 1);
  localparam int CAW = SB + PB + MB;
  localparam int IW  = ((PB > 8) ? PB : 8) + 2;
  localparam int CW  = COUNT_WIDTH;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? '1 : s[CW-1:0];
  endfunction

  // Configuration registers
  logic [4:0]  modulus;
  logic [5:0]  max_size;
  logic [62:0] forbidden_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus        <= MODULUS_RST;
      max_size       <= MAX_SIZE_RST;
      forbidden_mask <= FORBID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODULUS:  modulus        <= cfg_data[4:0];
        CFG_MAX_SIZE: max_size       <= cfg_data[5:0];
        CFG_FORBID:   forbidden_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Run state
  logic [MW-1:0]   m;
  logic [SB-1:0]   top;
  logic [SB-1:0]   n;
  logic [PB:0]     p;
  logic [MB-1:0]   pr;
  logic [MB-1:0]   rr;
  logic [CW-1:0]   acc;
  logic [CW-1:0]   total;
  logic [CW-1:0]   cur [MOD_MAX];
  logic            zero_sel;
  logic            zero_val;

  // Clamped config values
  logic [MW-1:0] m_clamp;
  logic [SB-1:0] top_clamp;
  always_comb begin
    if (modulus == 5'd0) begin
      m_clamp = MW'(1);
    end else if (32'(modulus) > MOD_MAX) begin
      m_clamp = MW'(MOD_MAX);
    end else begin
      m_clamp = MW'(modulus);
    end
    top_clamp = (32'(max_size) > SIZE_MAX) ? SB'(SIZE_MAX) : SB'(max_size);
  end

  // Status
  logic [MW-1:0] m_last;
  logic          pr_last;
  assign m_last         = m - MW'(1);
  assign pr_last        = (MW'(pr) == m_last);
  assign status.rr_last = (MW'(rr) == m_last);
  assign status.p_over  = (32'(p) > 32'(n)) || (32'(p) > PART_MAX);
  assign status.forbid  = (32'(p) >= 1) && (32'(p) <= 63) && forbidden_mask[6'(p - 1'b1)];
  assign status.n_last  = (n == top);

  // Difference table
  logic            diff_we;
  logic [2*MB-1:0] diff_waddr;
  logic [2*MB-1:0] diff_raddr;
  logic [7:0]      diff_rdata;

  assign diff_we    = cmd.load_diff && (32'(row) < MOD_MAX) && (32'(col) < MOD_MAX);
  assign diff_waddr = {MB'(row), MB'(col)};
  assign diff_raddr = {pr, rr};

  rpc_ram #(.WIDTH(8), .DEPTH(2 ** (2 * MB))) u_diff_ram (
    .clk   (clk),
    .we    (diff_we),
    .waddr (diff_waddr),
    .wdata (diff_value),
    .raddr (diff_raddr),
    .rdata (diff_rdata)
  );

  // Lookup bound: max(p - d, 0) clamped to s and PART_MAX
  logic [SB-1:0]       s;
  logic signed [IW-1:0] idx_raw;
  logic [IW-2:0]       idx_u;
  logic [IW-2:0]       lim;
  logic [PB-1:0]       idx;
  always_comb begin
    s       = n - SB'(p);
    idx_raw = $signed({{(IW-PB-1){1'b0}}, p}) - $signed({{(IW-8){diff_rdata[7]}}, diff_rdata});
    idx_u   = idx_raw[IW-2:0];
    lim     = (32'(s) > PART_MAX) ? (IW-1)'(PART_MAX) : (IW-1)'(s);
    if (idx_raw[IW-1]) begin
      idx = '0;
    end else if (idx_u > lim) begin
      idx = PB'(lim);
    end else begin
      idx = PB'(idx_u);
    end
  end

  // Count table
  logic            cnt_we;
  logic [CAW-1:0]  cnt_waddr;
  logic [CAW-1:0]  cnt_raddr;
  logic [CW-1:0]   cnt_rdata;
  logic [MB-1:0]   cur_ra;
  logic [CW-1:0]   cur_rd;

  assign cur_ra    = cmd.p_start ? pr : rr;
  assign cur_rd    = cur[cur_ra];
  assign cnt_we    = cmd.wr_row;
  assign cnt_waddr = {n, PB'(p), rr};
  assign cnt_raddr = {s, idx, rr};

  rpc_ram #(.WIDTH(CW), .DEPTH(2 ** CAW)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cur_rd),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Row zero is never stored: it holds 1 only at size 0, residue 0
  logic [CW-1:0] term;
  logic [CW-1:0] acc_sum;
  assign term    = zero_sel ? CW'(zero_val) : cnt_rdata;
  assign acc_sum = sat_add(acc, term);

  // Counters, accumulators and row vector
  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      m   <= m_clamp;
      top <= top_clamp;
      n   <= '0;
    end
    if (cmd.n_inc) begin
      n <= n + 1'b1;
    end
    if (cmd.row_init) begin
      p     <= (PB+1)'(1);
      pr    <= (m == MW'(1)) ? '0 : MB'(1);
      rr    <= '0;
      total <= '0;
      for (int i = 0; i < MOD_MAX; i++) begin
        cur[i] <= (n == '0 && i == 0) ? CW'(1) : '0;
      end
    end
    if (cmd.p_start) begin
      acc <= cur_rd;
      rr  <= '0;
    end
    if (cmd.rd_cnt) begin
      zero_sel <= (idx == '0);
      zero_val <= (s == '0) && (rr == '0);
    end
    if (cmd.acc_step) begin
      acc <= acc_sum;
      if (status.rr_last) begin
        cur[pr] <= acc_sum;
        rr      <= '0;
      end else begin
        rr <= rr + 1'b1;
      end
    end
    if (cmd.wr_row) begin
      if (status.rr_last) begin
        rr <= '0;
        p  <= p + 1'b1;
        pr <= pr_last ? '0 : pr + 1'b1;
      end else begin
        rr <= rr + 1'b1;
      end
    end
    if (cmd.sum_step) begin
      total <= sat_add(total, cur_rd);
      rr    <= status.rr_last ? '0 : rr + 1'b1;
    end
  end

  // Result fields
  assign size  = 6'(n);
  assign count = 32'(total);
  assign last  = status.n_last;

endmodule

// File: dv/tb_restricted_partition_counter.sv
// Testbench for the restricted partition counter: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module tb_restricted_partition_counter;
  import rpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int LONG_HOLD      = 3000;
  localparam int SETTLE_CYCLES  = 30;
  localparam int RANDOM_ITEMS   = 20;
  localparam int FILL_MOD       = 8;

  typedef enum logic [1:0] { ROW_LOAD, ROW_RUN, ROW_CFG } row_kind_t;

  // One directed stimulus row
  typedef struct {
    row_kind_t   kind;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [7:0]  diff;
    logic [4:0]  modulus;
    logic [5:0]  max_size;
    logic [62:0] forbid;
    bit          chk;
    logic [31:0] size0_count;
  } dir_row_t;

  // One partition count as emitted
  typedef struct {
    logic [5:0]  size;
    logic [31:0] count;
    logic        last;
  } count_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // row [3:0], col [7:4], diff_value [15:8]
  logic        s_tuser = 1'b0; // func [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // size [5:0], count [37:6], zero [39:38]
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_MODULUS;
  logic [62:0] cfg_data = '0;

  restricted_partition_counter dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  logic signed [7:0] diff_mem [16][16];
  logic [4:0]        mod_reg;
  logic [5:0]        max_reg;
  logic [62:0]       forbid_reg;
  longint unsigned   part_counts [64][64][16];
  count_result_t     pending_counts [$];

  int  errors = 0;
  int  results_seen = 0;
  bit  calm = 1'b0;
  bit  held = 1'b0;
  int  items_sent = 0;
  count_result_t got;
  count_result_t want;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                 input longint unsigned got_v);
    $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    errors++;
  endtask

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
  endfunction

  // Full DP recount; queues one expected count per size
  function automatic void predict_counts();
    int m, top, pr, d, s, idx, bound;
    longint unsigned total;
    count_result_t res;
    m = (mod_reg == 0) ? 1 : ((mod_reg > 16) ? 16 : int'(mod_reg));
    top = int'(max_reg);
    foreach (part_counts[a, b, c]) part_counts[a][b][c] = 0;
    part_counts[0][0][0] = 1;
    for (int n = 0; n <= top; n++) begin
      for (int p = 1; p <= 63; p++) begin
        pr = p % m;
        for (int r = 0; r < m; r++) part_counts[n][p][r] = part_counts[n][p-1][r];
        if (p > n || forbid_reg[p-1]) continue;
        for (int r = 0; r < m; r++) begin
          d = diff_mem[pr][r];
          s = n - p;
          idx = p - d;
          if (idx < 0) idx = 0;
          if (idx > s) idx = s;
          part_counts[n][p][pr] = sat_sum(part_counts[n][p][pr], part_counts[s][idx][r]);
        end
      end
      bound = n;
      total = 0;
      for (int k = 0; k < m; k++) total = sat_sum(total, part_counts[n][bound][k]);
      res.size = n[5:0];
      res.count = total[31:0];
      res.last = (n == top);
      pending_counts.insert(pending_counts.size(), res);
    end
  endfunction

  // Offer one item; predict once it is taken
  task automatic send_item(input logic func, input logic [3:0] row, input logic [3:0] col,
                           input logic [7:0] diff);
    int gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {diff, col, row};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (func == FUNC_LOAD) diff_mem[row][col] = diff;
    else predict_counts();
  endtask

  // Wait until every expected count has come back and the block is idle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges
  task automatic apply_settings(input logic [4:0] m, input logic [5:0] top,
                                input logic [62:0] mask);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MODULUS;
    cfg_data <= {58'd0, m};
    @(posedge clk);
    cfg_index <= CFG_MAX_SIZE;
    cfg_data <= {57'd0, top};
    @(posedge clk);
    cfg_index <= CFG_FORBID;
    cfg_data <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
    mod_reg = m;
    max_reg = top;
    forbid_reg = mask;
  endtask

  // Receiver: random bursts of backpressure, one long hold-off
  initial begin
    @(posedge clk);
    forever begin
      if (!calm && !held && results_seen >= 40) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Scoreboard on output transfers
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got.size = m_tdata[5:0];
      got.count = m_tdata[37:6];
      got.last = m_tlast;
      if (pending_counts.size() == 0) begin
        report_mismatch("unexpected result, size", 0, got.size);
      end else begin
        want = pending_counts.pop_front();
        if (got.size != want.size) report_mismatch("size", want.size, got.size);
        if (got.count != want.count) report_mismatch("count", want.count, got.count);
        if (got.last != want.last) report_mismatch("last", want.last, got.last);
      end
    end
  end

  // Watchdog on cycles with no transfer at all
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  dir_row_t dir_rows [$];

  function automatic dir_row_t mk(row_kind_t k, logic [3:0] r, logic [3:0] c, logic [7:0] d,
                                  logic [4:0] m, logic [5:0] top, logic [62:0] mask, bit chk);
    dir_row_t x;
    x.kind = k; x.row = r; x.col = c; x.diff = d;
    x.modulus = m; x.max_size = top; x.forbid = mask;
    x.chk = chk; x.size0_count = 32'd1;
    return x;
  endfunction

  function automatic void add_row(dir_row_t x);
    dir_rows.insert(dir_rows.size(), x);
  endfunction

  initial begin
    int base, n_items, phase_len;
    logic [4:0] rm;
    logic [5:0] rtop;
    logic [62:0] rmask;
    mod_reg = MODULUS_RST;
    max_reg = MAX_SIZE_RST;
    forbid_reg = FORBID_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the entries that runs with modulus up to FILL_MOD read
    for (int r = 0; r < FILL_MOD; r++)
      for (int c = 0; c < FILL_MOD; c++)
        send_item(FUNC_LOAD, r[3:0], c[3:0], 8'($urandom_range(0, 255)));

    // Directed: field extremes, both functions, register extremes
    add_row(mk(ROW_LOAD, 4'd0, 4'd0, 8'h80, 5'd0, 6'd0, '0, 1'b0));
    add_row(mk(ROW_LOAD, 4'd15, 4'd15, 8'h7F, 5'd0, 6'd0, '0, 1'b0));
    add_row(mk(ROW_LOAD, 4'd0, 4'd15, 8'h00, 5'd0, 6'd0, '0, 1'b0));
    add_row(mk(ROW_LOAD, 4'd15, 4'd0, 8'hFF, 5'd0, 6'd0, '0, 1'b0));
    add_row(mk(ROW_RUN, 4'd0, 4'd0, 8'h00, 5'd0, 6'd0, '0, 1'b1));       // reset settings
    add_row(mk(ROW_LOAD, 4'd1, 4'd1, 8'h01, 5'd0, 6'd0, '0, 1'b0));      // offered mid-run
    add_row(mk(ROW_CFG, 4'd0, 4'd0, 8'h00, 5'd0, 6'd0, '0, 1'b0));       // modulus 0 as 1
    add_row(mk(ROW_RUN, 4'd0, 4'd0, 8'h00, 5'd0, 6'd0, '0, 1'b1));
    add_row(mk(ROW_CFG, 4'd0, 4'd0, 8'h00, 5'd1, 6'd63, '1, 1'b0));      // every part banned
    add_row(mk(ROW_RUN, 4'd0, 4'd0, 8'h00, 5'd0, 6'd0, '0, 1'b1));
    add_row(mk(ROW_CFG, 4'd0, 4'd0, 8'h00, 5'd7, 6'd63, '0, 1'b0));      // odd modulus
    add_row(mk(ROW_RUN, 4'd0, 4'd0, 8'h00, 5'd0, 6'd0, '0, 1'b1));
    add_row(mk(ROW_CFG, 4'd0, 4'd0, 8'h00, 5'd6, 6'd10, 63'({32{2'b01}}), 1'b0));
    add_row(mk(ROW_LOAD, 4'd3, 4'd4, 8'h80, 5'd0, 6'd0, '0, 1'b0));
    add_row(mk(ROW_RUN, 4'd0, 4'd0, 8'h00, 5'd0, 6'd0, '0, 1'b1));
    add_row(mk(ROW_CFG, 4'd0, 4'd0, 8'h00, 5'd2, 6'd63, 63'h4000_0000_0000_0000, 1'b0));
    add_row(mk(ROW_RUN, 4'd0, 4'd0, 8'h00, 5'd0, 6'd0, '0, 1'b1));
    add_row(mk(ROW_CFG, 4'd0, 4'd0, 8'h00, 5'd3, 6'd5, 63'({32{2'b10}}), 1'b0));
    add_row(mk(ROW_RUN, 4'd0, 4'd0, 8'h00, 5'd0, 6'd0, '0, 1'b1));

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_LOAD: begin
          send_item(FUNC_LOAD, dir_rows[i].row, dir_rows[i].col, dir_rows[i].diff);
        end
        ROW_RUN: begin
          send_item(FUNC_RUN, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    8'($urandom_range(0, 255)));
          base = pending_counts.size() - int'(max_reg) - 1;
          // empty partition is the only partition of size zero
          if (dir_rows[i].chk && pending_counts[base].count != dir_rows[i].size0_count)
            report_mismatch("size 0 count", dir_rows[i].size0_count,
                            pending_counts[base].count);
        end
        default: begin
          drain();
          apply_settings(dir_rows[i].modulus, dir_rows[i].max_size, dir_rows[i].forbid);
        end
      endcase
    end

    // Random phases: new settings, then mostly loads with some runs
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      drain();
      rm = 5'($urandom_range(0, FILL_MOD));
      rtop = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(21, 40))
                                         : 6'($urandom_range(0, 20));
      rmask = ($urandom_range(0, 3) == 0) ? '0 : 63'({$urandom, $urandom});
      if (n_items >= RANDOM_ITEMS / 2) calm = 1'b1;
      apply_settings(rm, rtop, rmask);
      phase_len = $urandom_range(8, 15);
      for (int j = 0; j < phase_len; j++) begin
        send_item(($urandom_range(0, 4) == 0) ? FUNC_RUN : FUNC_LOAD,
                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)));
        n_items++;
      end
    end

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
